[design/pip_pkg.sv]
package pip_pkg;

  // widths fixed by the port fields
  localparam int FIELD_W = 16;
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 5;
  // wide enough for any slot or count compared against the table depth
  localparam int SLOT_W  = 9;
  // holding width for a field before the low coordinate bits are taken
  localparam int WIDE_W  = 32;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } pip_kind_t;

  typedef struct packed {
    logic load_j;
    logic lhs;
    logic rhs;
  } pip_edge_ctrl_t;

endpackage

[design/pip_vertex_ram.sv]
module pip_vertex_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/pip_edge_unit.sv]
module pip_edge_unit
  import pip_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pip_edge_ctrl_t               ctrl,
  input  logic signed [COORD_BITS-1:0] rd_x,
  input  logic signed [COORD_BITS-1:0] rd_y,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  output logic                         toggle
);

  localparam int D = COORD_BITS + 1;
  localparam int P = 2 * D;

  logic signed [COORD_BITS-1:0] xi, yi, xj, yj;
  logic signed [D-1:0]          op_a, op_b;
  logic signed [P-1:0]          prod;
  logic signed [P-1:0]          lhs, rhs;
  logic                         up, down, in_span, pending;

  // one multiplier, two passes per edge:
  // lhs pass (yj-yi)*(px-xi) with vertex i straight off the RAM,
  // rhs pass (xj-xi)*(py-yi) with vertex i from its register
  always_comb begin
    if (ctrl.lhs) begin
      op_a = D'(yj) - D'(rd_y);
      op_b = D'(px) - D'(rd_x);
    end else begin
      op_a = D'(xj) - D'(xi);
      op_b = D'(py) - D'(yi);
    end
  end

  assign prod = op_a * op_b;

  always_ff @(posedge clk) begin
    if (ctrl.load_j) begin
      xj <= rd_x;
      yj <= rd_y;
    end
    if (ctrl.lhs) begin
      xi  <= rd_x;
      yi  <= rd_y;
      lhs <= prod;
    end
    if (ctrl.rhs) begin
      rhs     <= prod;
      up      <= yi < yj;
      down    <= yi > yj;
      in_span <= (yi < yj) ? ((yi <= py) && (py <= yj)) : ((yj <= py) && (py <= yi));
      // this vertex closes the next edge
      xj      <= xi;
      yj      <= yi;
    end
  end

  // compare runs the cycle after the rhs pass
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else begin
      pending <= ctrl.rhs;
    end
  end

  assign toggle = pending && in_span && ((up && (lhs > rhs)) || (down && (lhs < rhs)));

endmodule

[design/point_in_polygon_test_unit.sv]
// Even-odd point-in-polygon test over a stored polygon. A vertex write
// (kind 0) never raises busy. A query (kind 1) holds busy through LOAD_J,
// an LHS and an RHS pass per edge and TALLY, n being vertex_count capped at
// MAX_VERTICES; the answer appears on inside_res with done high for exactly
// one cycle. With n zero, busy stays low and the answer follows in the cycle
// after the transfer. Passes come from the single shared multiplier, used
// twice per edge, and the one read port of the vertex RAM. Results cannot be
// held off: the receiver must take done when it comes. The user must write
// vertex_count through cfg_wr/cfg_data only while idle; no logic enforces it.
module point_in_polygon_test_unit
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      kind,
  input  logic [INDEX_W-1:0]        vertex_index,
  input  logic signed [FIELD_W-1:0] coord_x,
  input  logic signed [FIELD_W-1:0] coord_y,
  input  logic                      cfg_wr,
  input  logic [COUNT_W-1:0]        cfg_data,
  output logic                      done,
  output logic                      inside_res
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [2:0] {
    IDLE,
    LOAD_J,
    LHS,
    RHS,
    TALLY
  } state_t;

  state_t                      state;
  logic [COUNT_W-1:0]          vertex_count;
  logic [AW-1:0]               idx;
  logic                        parity;
  logic signed [COORD_BITS-1:0] px, py;

  logic                        accept;
  logic [WIDE_W-1:0]           x_wide, y_wide;
  logic signed [COORD_BITS-1:0] cx, cy;
  logic [SLOT_W-1:0]           slot_wide, count_wide, n_wide;
  logic [CW-1:0]               n, n_m1;
  logic [AW-1:0]               last, raddr;
  logic                        we;
  logic [2*COORD_BITS-1:0]     rdata;
  pip_edge_ctrl_t              ctrl;
  logic                        toggle;

  assign accept = start && !busy;
  assign busy   = (state != IDLE);

  // low COORD_BITS of the field, sign taken from that width
  assign x_wide = {{(WIDE_W-FIELD_W){1'b0}}, coord_x};
  assign y_wide = {{(WIDE_W-FIELD_W){1'b0}}, coord_y};
  assign cx     = x_wide[COORD_BITS-1:0];
  assign cy     = y_wide[COORD_BITS-1:0];

  assign slot_wide  = {{(SLOT_W-INDEX_W){1'b0}}, vertex_index};
  assign count_wide = {{(SLOT_W-COUNT_W){1'b0}}, vertex_count};
  assign n_wide     = (count_wide > SLOT_W'(MAX_VERTICES)) ? SLOT_W'(MAX_VERTICES) : count_wide;
  assign n          = n_wide[CW-1:0];
  assign n_m1       = n - CW'(1);
  assign last       = n_m1[AW-1:0];

  assign we = accept && (kind == KIND_WRITE) && (slot_wide < SLOT_W'(MAX_VERTICES));

  always_comb begin
    case (state)
      IDLE:    raddr = last;
      LOAD_J:  raddr = '0;
      RHS:     raddr = (idx == last) ? idx : idx + AW'(1);
      default: raddr = idx;
    endcase
  end

  assign ctrl.load_j = (state == LOAD_J);
  assign ctrl.lhs    = (state == LHS);
  assign ctrl.rhs    = (state == RHS);

  pip_vertex_ram #(
    .DEPTH(MAX_VERTICES),
    .WIDTH(2*COORD_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(slot_wide[AW-1:0]),
    .wdata({cx, cy}),
    .raddr(raddr),
    .rdata(rdata)
  );

  pip_edge_unit #(
    .COORD_BITS(COORD_BITS)
  ) u_edge (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .rd_x  (rdata[2*COORD_BITS-1:COORD_BITS]),
    .rd_y  (rdata[COORD_BITS-1:0]),
    .px    (px),
    .py    (py),
    .toggle(toggle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_wr) begin
      vertex_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px <= cx;
      py <= cy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      done       <= 1'b0;
      inside_res <= 1'b0;
      parity     <= 1'b0;
      idx        <= '0;
    end else begin
      done   <= 1'b0;
      parity <= parity ^ toggle;
      case (state)
        IDLE: begin
          if (accept && (kind == KIND_QUERY)) begin
            parity <= 1'b0;
            idx    <= '0;
            if (n == '0) begin
              inside_res <= 1'b0;
              done       <= 1'b1;
            end else begin
              state <= LOAD_J;
            end
          end
        end
        LOAD_J: state <= LHS;
        LHS:    state <= RHS;
        RHS: begin
          if (idx == last) begin
            state <= TALLY;
          end else begin
            idx   <= idx + AW'(1);
            state <= LHS;
          end
        end
        TALLY: begin
          // last edge's compare lands here
          inside_res <= parity ^ toggle;
          done       <= 1'b1;
          state      <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[design/pip_checker.sv]
module pip_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic kind,
  input logic done
);

  // vertex write never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !kind) |=> !done)
    else $error("result after vertex write");

  // query transfer is followed by work or an answer
  a_query_moves: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind) |=> (done || busy))
    else $error("query dropped");

  // no result without a query behind it
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || (start && kind)))
    else $error("spurious result");

  // a result ends the query's work
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (done && $past(busy)) |-> !busy)
    else $error("busy after result");

  a_reset: assert property (@(posedge clk) rst |=> (!busy && !done))
    else $error("reset state wrong");

endmodule

bind point_in_polygon_test_unit pip_checker u_pip_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .kind (kind),
  .done (done)
);

[sim/tb_point_in_polygon_test_unit.sv]
module tb_point_in_polygon_test_unit;
  import pip_pkg::*;

  localparam int MAX_V        = 16;
  localparam int SETTLE       = 4;
  localparam int DRAIN        = 60;
  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 300000;

  // Even-odd crossing predictor plus the queue of outstanding answers.
  class inside_scoreboard;
    logic signed [FIELD_W-1:0] vx [MAX_V];
    logic signed [FIELD_W-1:0] vy [MAX_V];
    logic [COUNT_W-1:0] vertex_count;
    logic expected_inside [$];
    int errors;

    function new();
      vertex_count = '0;
      errors = 0;
    endfunction

    function void write_count(logic [COUNT_W-1:0] v);
      vertex_count = v;
    endfunction

    function logic edge_flips(input logic signed [FIELD_W-1:0] xi, yi, xj, yj, px, py);
      logic signed [FIELD_W:0] dy, dx, dpx, dpy;
      logic signed [2*FIELD_W+1:0] lhs, rhs;
      if (yi == yj) return 1'b0;
      dy  = yj - yi;
      dx  = xj - xi;
      dpx = px - xi;
      dpy = py - yi;
      lhs = dy * dpx;
      rhs = dx * dpy;
      if (yi < yj) return (yi <= py) && (py <= yj) && (lhs > rhs);
      return (yj <= py) && (py <= yi) && (lhs < rhs);
    endfunction

    function logic predict_inside(logic signed [FIELD_W-1:0] px, py);
      int n;
      int j;
      logic flag;
      n = (vertex_count > MAX_V) ? MAX_V : vertex_count;
      flag = 1'b0;
      j = n - 1;
      for (int i = 0; i < n; i++) begin
        if (edge_flips(vx[i], vy[i], vx[j], vy[j], px, py)) flag = !flag;
        j = i;
      end
      return flag;
    endfunction

    function void note_transfer(pip_kind_t k, logic [INDEX_W-1:0] slot,
                                logic signed [FIELD_W-1:0] x, y);
      if (k == KIND_WRITE) begin
        vx[slot] = x;
        vy[slot] = y;
      end else begin
        expected_inside.push_back(predict_inside(x, y));
      end
    endfunction

    function void check_result(logic got);
      logic want;
      if (expected_inside.size() == 0) begin
        $display("%0t: inside_res %0b with no query outstanding (expected none)", $time, got);
        errors++;
      end else begin
        want = expected_inside.pop_front();
        if (got !== want) begin
          $display("%0t: inside_res mismatch: expected %0b, actual %0b", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic                      kind;
  logic [INDEX_W-1:0]        vertex_index;
  logic signed [FIELD_W-1:0] coord_x;
  logic signed [FIELD_W-1:0] coord_y;
  logic                      cfg_wr;
  logic [COUNT_W-1:0]        cfg_data;
  logic                      done;
  logic                      inside_res;

  inside_scoreboard sb;
  int cycles;
  int burst_left;

  point_in_polygon_test_unit #(
    .MAX_VERTICES(MAX_V),
    .COORD_BITS  (FIELD_W)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .vertex_index(vertex_index),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .cfg_wr      (cfg_wr),
    .cfg_data    (cfg_data),
    .done        (done),
    .inside_res  (inside_res)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // answers are checked before new transfers are noted on the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(inside_res);
      if (start && !busy)
        sb.note_transfer(pip_kind_t'(kind), vertex_index, coord_x, coord_y);
      if (cfg_wr) sb.write_count(cfg_data);
    end
  end

  task automatic send_item(pip_kind_t k, logic [INDEX_W-1:0] slot,
                           logic signed [FIELD_W-1:0] x, y);
    start        <= 1'b1;
    kind         <= k;
    vertex_index <= slot;
    coord_x      <= x;
    coord_y      <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(int n);
    start        <= 1'b0;
    kind         <= 1'($urandom);
    vertex_index <= INDEX_W'($urandom);
    coord_x      <= FIELD_W'($urandom);
    coord_y      <= FIELD_W'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic after_item();
    burst_left--;
    if (burst_left <= 0) begin
      pause($urandom_range(1, ($urandom_range(3) == 0) ? 40 : 6));
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  // the edge after the last transfer guarantees its expectation is queued
  task automatic wait_answers(int extra);
    pause(1);
    while (sb.expected_inside.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_count(logic [COUNT_W-1:0] v);
    wait_answers(SETTLE);
    cfg_wr   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_wr   <= 1'b0;
  endtask

  function automatic logic signed [FIELD_W-1:0] coord_near(int span);
    int v;
    v = int'($urandom_range(2 * span)) - span;
    return v[FIELD_W-1:0];
  endfunction

  task automatic directed_items();
    // empty polygon straight after reset
    send_item(KIND_QUERY, 4'h0, 16'sh7FFF, 16'sh8000);
    send_item(KIND_QUERY, 4'hF, 16'sh8000, 16'sh7FFF);
    // extreme square in slots 0..3, zigzag in the rest
    send_item(KIND_WRITE, 4'd0, 16'sh8000, 16'sh8000);
    send_item(KIND_WRITE, 4'd1, 16'sh7FFF, 16'sh8000);
    send_item(KIND_WRITE, 4'd2, 16'sh7FFF, 16'sh7FFF);
    send_item(KIND_WRITE, 4'd3, 16'sh8000, 16'sh7FFF);
    for (int i = 4; i < MAX_V; i++)
      send_item(KIND_WRITE, INDEX_W'(i), FIELD_W'((i - 4) * 2000 - 12000),
                FIELD_W'((i % 2) ? 3000 : -3000));
    set_count(5'd4);
    send_item(KIND_QUERY, 4'h0, 16'sh0000, 16'sh0000);
    send_item(KIND_QUERY, 4'h0, 16'sh8000, 16'sh0000);
    send_item(KIND_QUERY, 4'h0, 16'sh7FFF, 16'sh7FFF);
    // single vertex: horizontal self-edge
    set_count(5'd1);
    send_item(KIND_QUERY, 4'h0, 16'sh8000, 16'sh8000);
    // two vertices, both on the bottom line
    set_count(5'd2);
    send_item(KIND_QUERY, 4'h0, 16'sh0000, 16'sh8000);
    // count above the table saturates
    set_count(5'd31);
    send_item(KIND_QUERY, 4'h0, 16'sh0000, 16'sh0000);
    set_count(5'd3);
    send_item(KIND_QUERY, 4'h0, 16'sh0001, 16'sh0001);
  endtask

  task automatic random_phases();
    int sent;
    int cnt;
    int n;
    int span;
    int nq;
    int k;
    int k2;
    int r;
    logic signed [FIELD_W-1:0] px, py;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(9);
      case (r)
        0: cnt = 0;
        1: cnt = $urandom_range(1, 2);
        2: cnt = $urandom_range(17, 31);
        3: cnt = MAX_V;
        default: cnt = $urandom_range(3, MAX_V);
      endcase
      set_count(COUNT_W'(cnt));
      n = (cnt > MAX_V) ? MAX_V : cnt;
      case ($urandom_range(3))
        0: span = 4;
        1: span = 64;
        2: span = 2000;
        default: span = 32767;
      endcase
      // fresh polygon most of the time
      if ($urandom_range(3) != 0) begin
        for (int i = 0; i < n; i++) begin
          send_item(KIND_WRITE, INDEX_W'(i), coord_near(span), coord_near(span));
          after_item();
          sent++;
        end
      end
      nq = $urandom_range(4, 24);
      repeat (nq) begin
        if ($urandom_range(9) == 0) begin
          send_item(KIND_WRITE, INDEX_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
        end else begin
          r = (n == 0) ? 9 : $urandom_range(9);
          k = (n == 0) ? 0 : $urandom_range(n - 1);
          k2 = (k == 0) ? n - 1 : k - 1;
          case (r)
            0: begin
              px = FIELD_W'($urandom);
              py = FIELD_W'($urandom);
            end
            1, 2: begin
              px = sb.vx[k];
              py = sb.vy[k];
            end
            3: begin
              px = coord_near(span);
              py = sb.vy[k];
            end
            4: begin
              // edge midpoint, on or next to the boundary
              px = FIELD_W'((int'(sb.vx[k]) + int'(sb.vx[k2])) / 2);
              py = FIELD_W'((int'(sb.vy[k]) + int'(sb.vy[k2])) / 2);
            end
            default: begin
              px = coord_near(span);
              py = coord_near(span);
            end
          endcase
          send_item(KIND_QUERY, INDEX_W'($urandom), px, py);
        end
        after_item();
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    cycles       <= 0;
    rst          <= 1'b1;
    start        <= 1'b0;
    kind         <= 1'b0;
    vertex_index <= '0;
    coord_x      <= '0;
    coord_y      <= '0;
    cfg_wr       <= 1'b0;
    cfg_data     <= '0;
    burst_left = 1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    directed_items();
    random_phases();
    wait_answers(DRAIN);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
